// ===== src/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// shared widths, payload types and defaults for the lfu cache
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_W         = 32;
  localparam int VALUE_W       = 32;
  localparam int CFG_W         = 5;
  localparam int LFU_ENTRIES   = 16;
  localparam int LFU_COUNT_W   = 16;
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic               op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } lfu_in_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
  } lfu_out_t;

endpackage

// ===== src/lfu_ram.sv =====
// ----------------------------------------------------------------------------
// lfu_ram
// generic simple dual-port ram, one write port, registered read
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lfu_scan.sv =====
// ----------------------------------------------------------------------------
// lfu_scan
// walks the entries one per ent_vld cycle: key match, first free slot, lfu/lru victim
// ----------------------------------------------------------------------------
module lfu_scan import lfu_pkg::*; #(
  parameter int ENTRIES    = LFU_ENTRIES,
  parameter int COUNT_BITS = LFU_COUNT_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    clear,
  input  logic                    ent_vld,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] ent_idx,
  input  logic                    ent_valid,
  input  logic [KEY_W-1:0]        ent_key,
  input  logic [VALUE_W-1:0]      ent_value,
  input  logic [COUNT_BITS-1:0]   ent_count,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] ent_rank,
  input  logic [KEY_W-1:0]        lookup_key,
  output logic                    hit,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] hit_idx,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] hit_rank,
  output logic [VALUE_W-1:0]      hit_value,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] free_idx,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] vic_idx,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] vic_rank
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic                  hit_r;
  logic                  free_found_r;
  logic                  vic_found_r;
  logic [IW-1:0]         hit_idx_r;
  logic [IW-1:0]         hit_rank_r;
  logic [VALUE_W-1:0]    hit_value_r;
  logic [IW-1:0]         free_idx_r;
  logic [IW-1:0]         vic_idx_r;
  logic [IW-1:0]         vic_rank_r;
  logic [COUNT_BITS-1:0] vic_count_r;
  logic                  better;

  // smaller count wins, equal count goes to the older entry
  assign better = !vic_found_r || (ent_count < vic_count_r) ||
                  ((ent_count == vic_count_r) && (ent_rank > vic_rank_r));

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      vic_found_r  <= 1'b0;
    end else if (ent_vld) begin
      if (ent_valid && (ent_key == lookup_key) && !hit_r) begin
        hit_r       <= 1'b1;
        hit_idx_r   <= ent_idx;
        hit_rank_r  <= ent_rank;
        hit_value_r <= ent_value;
      end
      if (!ent_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= ent_idx;
      end
      if (ent_valid && better) begin
        vic_found_r <= 1'b1;
        vic_idx_r   <= ent_idx;
        vic_rank_r  <= ent_rank;
        vic_count_r <= ent_count;
      end
    end
  end

  assign hit       = hit_r;
  assign hit_idx   = hit_idx_r;
  assign hit_rank  = hit_rank_r;
  assign hit_value = hit_value_r;
  assign free_idx  = free_idx_r;
  assign vic_idx   = vic_idx_r;
  assign vic_rank  = vic_rank_r;

endmodule

// ===== src/lfu_cache_lru_tiebreak.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// key/value store, lfu eviction with lru tie-break, entries held in one ram
// ----------------------------------------------------------------------------
// a get miss or a dropped put ends after the scan pass; a get that hits or any
//   put that changes state also runs the write-back pass over the entry ram
// throughput: one item at a time; busy covers the whole item, from the scan
//   pass to the write-back pass, if any, over the single entry ram
// the get result is a one-cycle out_valid strobe; the receiver cannot stall
// reset: synchronous, active low; clears valid bits, occupancy, fsm and
//   sets capacity to 16; ram contents are not cleared
module lfu_cache_lru_tiebreak import lfu_pkg::*; #(
  parameter int ENTRIES    = LFU_ENTRIES,
  parameter int COUNT_BITS = LFU_COUNT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lfu_in_t          in_data,
  output logic             out_valid,
  output lfu_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;  // index and rank width
  localparam int CW   = $clog2(ENTRIES + 1);                  // counter / occupancy width
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
  localparam int EW   = KEY_W + VALUE_W + COUNT_BITS + IW;

  // one ram word per entry
  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VALUE_W-1:0]    value;
    logic [COUNT_BITS-1:0] count;
    logic [IW-1:0]         rank;
  } entry_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_UPD} state_t;
  typedef enum logic [1:0] {MD_HIT, MD_EVICT, MD_FILL} mode_t;

  state_t              state_r;
  mode_t               mode_r;
  lfu_in_t             item_r;
  logic [CFG_W-1:0]    capacity_r;
  logic [CW-1:0]       occ_r;
  logic [ENTRIES-1:0]  valid_r;
  logic [CW-1:0]       cnt_r;
  logic                pend_r;
  logic [IW-1:0]       pidx_r;
  logic [IW-1:0]       tgt_r;
  logic [IW-1:0]       trank_r;
  logic                out_valid_r;
  lfu_out_t            out_data_r;

  entry_t              rd_ent;
  entry_t              wr_ent;
  logic [EW-1:0]       rdata;
  logic                ram_we;
  logic [CMPW-1:0]     cap_eff;
  logic                cnt_end;

  // scan results
  logic                s_hit;
  logic [IW-1:0]       s_hit_idx;
  logic [IW-1:0]       s_hit_rank;
  logic [VALUE_W-1:0]  s_hit_value;
  logic [IW-1:0]       s_free_idx;
  logic [IW-1:0]       s_vic_idx;
  logic [IW-1:0]       s_vic_rank;

  assign rd_ent  = entry_t'(rdata);
  assign cnt_end = (cnt_r == CW'(ENTRIES));
  assign ram_we  = pend_r && (state_r == ST_UPD);

  // capacity above the entry count behaves as the entry count
  assign cap_eff = (CMPW'(capacity_r) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES)
                                                        : CMPW'(capacity_r);

  lfu_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pidx_r),
    .wdata (wr_ent),
    .raddr (cnt_r[IW-1:0]),
    .rdata (rdata)
  );

  lfu_scan #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (start && !busy),
    .ent_vld    (pend_r && (state_r == ST_SCAN)),
    .ent_idx    (pidx_r),
    .ent_valid  (valid_r[pidx_r]),
    .ent_key    (rd_ent.key),
    .ent_value  (rd_ent.value),
    .ent_count  (rd_ent.count),
    .ent_rank   (rd_ent.rank),
    .lookup_key (item_r.key),
    .hit        (s_hit),
    .hit_idx    (s_hit_idx),
    .hit_rank   (s_hit_rank),
    .hit_value  (s_hit_value),
    .free_idx   (s_free_idx),
    .vic_idx    (s_vic_idx),
    .vic_rank   (s_vic_rank)
  );

  // write-back word for the entry read in the previous cycle
  always_comb begin
    wr_ent = rd_ent;
    if (pidx_r == tgt_r) begin
      if (mode_r == MD_HIT) begin
        // saturating use count, becomes most recent
        if (rd_ent.count != {COUNT_BITS{1'b1}}) begin
          wr_ent.count = rd_ent.count + COUNT_BITS'(1);
        end
        wr_ent.rank = '0;
        if (item_r.op == OP_PUT) begin
          wr_ent.value = item_r.value;
        end
      end else begin
        // new key lands in the victim or free slot
        wr_ent.key   = item_r.key;
        wr_ent.value = item_r.value;
        wr_ent.count = COUNT_BITS'(1);
        wr_ent.rank  = '0;
      end
    end else if (valid_r[pidx_r]) begin
      case (mode_r)
        MD_HIT: begin
          // younger entries age by one
          if (rd_ent.rank < trank_r) begin
            wr_ent.rank = rd_ent.rank + IW'(1);
          end
        end
        MD_EVICT: begin
          // close the gap left by the victim, then age for the new entry
          wr_ent.rank = rd_ent.rank - IW'(rd_ent.rank > trank_r) + IW'(1);
        end
        MD_FILL: begin
          wr_ent.rank = rd_ent.rank + IW'(1);
        end
        default: begin
          wr_ent.rank = rd_ent.rank;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MD_HIT;
      capacity_r  <= CAP_RESET;
      occ_r       <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      // read pipeline: address issued now, data seen next cycle
      pend_r <= ((state_r == ST_SCAN) || (state_r == ST_UPD)) && !cnt_end;
      pidx_r <= cnt_r[IW-1:0];
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            item_r  <= in_data;
            cnt_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_end) begin
            state_r <= ST_DECIDE;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        ST_DECIDE: begin
          cnt_r <= '0;
          if (item_r.op == OP_GET) begin
            if (s_hit) begin
              mode_r  <= MD_HIT;
              tgt_r   <= s_hit_idx;
              trank_r <= s_hit_rank;
              state_r <= ST_UPD;
            end else begin
              out_valid_r           <= 1'b1;
              out_data_r.hit        <= 1'b0;
              out_data_r.read_value <= '0;
              state_r               <= ST_IDLE;
            end
          end else if (cap_eff == '0) begin
            // zero capacity: puts are dropped
            state_r <= ST_IDLE;
          end else if (s_hit) begin
            mode_r  <= MD_HIT;
            tgt_r   <= s_hit_idx;
            trank_r <= s_hit_rank;
            state_r <= ST_UPD;
          end else if (CMPW'(occ_r) >= cap_eff) begin
            mode_r  <= MD_EVICT;
            tgt_r   <= s_vic_idx;
            trank_r <= s_vic_rank;
            state_r <= ST_UPD;
          end else begin
            mode_r  <= MD_FILL;
            tgt_r   <= s_free_idx;
            trank_r <= '0;
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (cnt_end) begin
            if (mode_r == MD_FILL) begin
              valid_r[tgt_r] <= 1'b1;
              occ_r          <= occ_r + CW'(1);
            end
            if (item_r.op == OP_GET) begin
              out_valid_r           <= 1'b1;
              out_data_r.hit        <= 1'b1;
              out_data_r.read_value <= s_hit_value;
            end
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/lfu_checker.sv =====
// ----------------------------------------------------------------------------
// lfu_checker
// port-level checks on the lfu cache, bound to the top level
// ----------------------------------------------------------------------------
module lfu_checker import lfu_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input lfu_out_t out_data
);

  // an accepted transfer keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  // a result closes its item
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // results of separate items are never adjacent
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe too long");

  // a miss reads as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.read_value == '0)
    else $error("miss with nonzero value");

  // reset idles the block
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("not idle after reset");

endmodule

bind lfu_cache_lru_tiebreak lfu_checker u_lfu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
